// ===== design/sai_pkg.sv =====
// Shared widths, slot type and arithmetic helpers for the segment/rectangle intersection block.
package sai_pkg;

  localparam int CoordW     = 32;               // Q16.16 coordinate
  localparam int DiffW      = CoordW + 1;       // difference of two coordinates
  localparam int ProdW      = 2 * DiffW;        // product of two differences
  localparam int WideW      = ProdW + 1;        // product after negate or subtract
  localparam int ThrW       = 63;               // parallel threshold register
  localparam int MagW       = 2 * CoordW;       // product magnitude, dividend
  localparam int NumEdges   = 4;
  localparam int DivSteps   = 2;                // quotient bits per divider stage
  localparam int DivStages  = CoordW / DivSteps;
  localparam int NumStages  = 5 + DivStages + 1;
  localparam int InDataW    = 8 * CoordW;
  localparam int OutDataW   = 136;

  // edges: top, right, bottom, left; top and bottom are horizontal
  localparam logic [NumEdges-1:0] EdgeHoriz = 4'b0101;

  // one pending intersection inside the divider
  typedef struct packed {
    logic              used;
    logic              horiz;
    logic              neg;
    logic [CoordW-1:0] base;
    logic [CoordW-1:0] fixed;
    logic [CoordW-1:0] dsor;
    logic [CoordW-1:0] rem;
    logic [CoordW-1:0] low;
  } div_slot_t;

  function automatic logic signed [ProdW-1:0] mul_diff(input logic signed [DiffW-1:0] a,
                                                       input logic signed [DiffW-1:0] b);
    logic signed [ProdW-1:0] ae;
    logic signed [ProdW-1:0] be;
    ae = a;
    be = b;
    return ae * be;
  endfunction

  // ratio num/den lies in [0,1]; den is nonzero
  function automatic logic in_unit(input logic signed [WideW-1:0] num,
                                   input logic signed [WideW-1:0] den);
    logic ok;
    if (num == '0) begin
      ok = 1'b1;
    end else if (num[WideW-1] != den[WideW-1]) begin
      ok = 1'b0;
    end else if (den[WideW-1]) begin
      ok = (num >= den);
    end else begin
      ok = (num <= den);
    end
    return ok;
  endfunction

  // one restoring division step: shift in a dividend bit, shift out a quotient bit
  function automatic div_slot_t div_step(input div_slot_t d);
    div_slot_t       r;
    logic [CoordW:0] trial;
    r = d;
    trial = {d.rem, d.low[CoordW-1]};
    if (trial >= {1'b0, d.dsor}) begin
      r.rem = CoordW'(trial - {1'b0, d.dsor});
      r.low = {d.low[CoordW-2:0], 1'b1};
    end else begin
      r.rem = trial[CoordW-1:0];
      r.low = {d.low[CoordW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== design/segment_aabb_intersections_top.sv =====
// Segment versus axis-aligned rectangle intersection: pipelined edge tests and dividers.
//
// Each request carries a segment and a rectangle in signed Q16.16; the block tests
// the top, right, bottom and left edges with exact cross products, keeps the first
// two hits and returns one result per request. It takes one request per clock while
// the output is not stalled; each result passes through 22 register stages:
// five stages of differences, products, signs and range checks, and hit selection,
// then a 16-stage restoring divider (two quotient bits per stage, one divider per hit
// slot) and a final output register. Stalls on the output back up stage by stage, so
// empty stages still fill while a result waits.
module segment_aabb_intersections_top
  import sai_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ThrW-1:0]     cfg_wdata,     // parallel_threshold
  input  logic                s_tvalid,
  output logic                s_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, left_x, top_y,
  // right_x, bottom_y (32 bits each)
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // hit_count[1:0], first_x, first_y, second_x, second_y, zero pad[135:130]
  output logic [OutDataW-1:0] m_tdata
);

  logic [ThrW-1:0]      thr;
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] adv;

  // stage 1: differences
  logic signed [CoordW-1:0] s1_ax, s1_ay;
  logic signed [DiffW-1:0]  s1_abx, s1_aby;
  logic signed [DiffW-1:0]  s1_acx [NumEdges];
  logic signed [DiffW-1:0]  s1_acy [NumEdges];
  logic signed [DiffW-1:0]  s1_len [NumEdges];
  logic [CoordW-1:0]        s1_cx  [NumEdges];
  logic [CoordW-1:0]        s1_cy  [NumEdges];

  // stage 2: products
  logic signed [CoordW-1:0] s2_ax, s2_ay;
  logic signed [DiffW-1:0]  s2_abx, s2_aby;
  logic signed [ProdW-1:0]  s2_dp [NumEdges];
  logic signed [ProdW-1:0]  s2_sp [NumEdges];
  logic signed [ProdW-1:0]  s2_p1 [NumEdges];
  logic signed [ProdW-1:0]  s2_p2 [NumEdges];
  logic [CoordW-1:0]        s2_cx [NumEdges];
  logic [CoordW-1:0]        s2_cy [NumEdges];

  // stage 3: signed numerators and denominators
  logic signed [CoordW-1:0] s3_ax, s3_ay;
  logic signed [DiffW-1:0]  s3_abx, s3_aby;
  logic signed [WideW-1:0]  s3_den  [NumEdges];
  logic signed [WideW-1:0]  s3_snum [NumEdges];
  logic signed [WideW-1:0]  s3_tnum [NumEdges];
  logic signed [ProdW-1:0]  s3_dvp  [NumEdges];
  logic [CoordW-1:0]        s3_cx   [NumEdges];
  logic [CoordW-1:0]        s3_cy   [NumEdges];

  // stage 4: hit flags
  logic signed [CoordW-1:0] s4_ax, s4_ay;
  logic signed [DiffW-1:0]  s4_abx, s4_aby;
  logic [NumEdges-1:0]      s4_hit;
  logic signed [ProdW-1:0]  s4_dvp [NumEdges];
  logic [CoordW-1:0]        s4_cx  [NumEdges];
  logic [CoordW-1:0]        s4_cy  [NumEdges];

  // divider pipeline; entry zero is the selection stage
  div_slot_t  dsl  [DivStages+1][2];
  logic [1:0] dcnt [DivStages+1];
  div_slot_t  sel_next [2];
  logic [1:0] cnt_next;

  // output stage
  logic [OutDataW-1:0] out_data;
  logic [OutDataW-1:0] out_data_next;

  // back up stalls stage by stage
  always_comb begin
    adv[NumStages-1] = !vld[NumStages-1] || m_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[NumStages-1];
  assign m_tdata  = out_data;

  // hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ThrW'(1);
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: unpack and take differences
  always_ff @(posedge clk) begin
    logic signed [DiffW-1:0] sx, sy, ex, ey, l, t, r, b;
    sx = DiffW'(signed'(s_tdata[0*CoordW +: CoordW]));
    sy = DiffW'(signed'(s_tdata[1*CoordW +: CoordW]));
    ex = DiffW'(signed'(s_tdata[2*CoordW +: CoordW]));
    ey = DiffW'(signed'(s_tdata[3*CoordW +: CoordW]));
    l  = DiffW'(signed'(s_tdata[4*CoordW +: CoordW]));
    t  = DiffW'(signed'(s_tdata[5*CoordW +: CoordW]));
    r  = DiffW'(signed'(s_tdata[6*CoordW +: CoordW]));
    b  = DiffW'(signed'(s_tdata[7*CoordW +: CoordW]));
    if (adv[0]) begin
      s1_ax  <= sx[CoordW-1:0];
      s1_ay  <= sy[CoordW-1:0];
      s1_abx <= ex - sx;
      s1_aby <= ey - sy;
      s1_len[0] <= r - l;
      s1_len[1] <= b - t;
      s1_len[2] <= l - r;
      s1_len[3] <= t - b;
      s1_acx[0] <= l - sx;
      s1_acx[1] <= r - sx;
      s1_acx[2] <= r - sx;
      s1_acx[3] <= l - sx;
      s1_acy[0] <= t - sy;
      s1_acy[1] <= t - sy;
      s1_acy[2] <= b - sy;
      s1_acy[3] <= b - sy;
      s1_cx[0] <= l[CoordW-1:0];
      s1_cx[1] <= r[CoordW-1:0];
      s1_cx[2] <= r[CoordW-1:0];
      s1_cx[3] <= l[CoordW-1:0];
      s1_cy[0] <= t[CoordW-1:0];
      s1_cy[1] <= t[CoordW-1:0];
      s1_cy[2] <= b[CoordW-1:0];
      s1_cy[3] <= b[CoordW-1:0];
    end
  end

  // stage 2: cross-product terms
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
      s2_abx <= s1_abx;
      s2_aby <= s1_aby;
      for (int i = 0; i < NumEdges; i++) begin
        s2_dp[i] <= mul_diff(EdgeHoriz[i] ? s1_aby : s1_abx, s1_len[i]);
        s2_sp[i] <= mul_diff(EdgeHoriz[i] ? s1_acy[i] : s1_acx[i], s1_len[i]);
        s2_p1[i] <= mul_diff(s1_acx[i], s1_aby);
        s2_p2[i] <= mul_diff(s1_acy[i], s1_abx);
        s2_cx[i] <= s1_cx[i];
        s2_cy[i] <= s1_cy[i];
      end
    end
  end

  // stage 3: apply edge orientation, form the t numerator
  always_ff @(posedge clk) begin
    logic signed [WideW-1:0] dpw, spw;
    if (adv[2]) begin
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_abx <= s2_abx;
      s3_aby <= s2_aby;
      for (int i = 0; i < NumEdges; i++) begin
        dpw = WideW'(s2_dp[i]);
        spw = WideW'(s2_sp[i]);
        s3_den[i]  <= EdgeHoriz[i] ? -dpw : dpw;
        s3_snum[i] <= EdgeHoriz[i] ? -spw : spw;
        s3_tnum[i] <= WideW'(s2_p1[i]) - WideW'(s2_p2[i]);
        s3_dvp[i]  <= EdgeHoriz[i] ? s2_p2[i] : s2_p1[i];
        s3_cx[i]   <= s2_cx[i];
        s3_cy[i]   <= s2_cy[i];
      end
    end
  end

  // stage 4: parallel and range checks
  always_ff @(posedge clk) begin
    logic signed [WideW-1:0] mag;
    if (adv[3]) begin
      s4_ax  <= s3_ax;
      s4_ay  <= s3_ay;
      s4_abx <= s3_abx;
      s4_aby <= s3_aby;
      for (int i = 0; i < NumEdges; i++) begin
        mag = s3_den[i][WideW-1] ? -s3_den[i] : s3_den[i];
        s4_hit[i] <= (mag != '0) && (mag[MagW-1:0] >= MagW'(thr))
                     && in_unit(s3_snum[i], s3_den[i]) && in_unit(s3_tnum[i], s3_den[i]);
        s4_dvp[i] <= s3_dvp[i];
        s4_cx[i]  <= s3_cx[i];
        s4_cy[i]  <= s3_cy[i];
      end
    end
  end

  // stage 5: pick the first two hits and set up the dividers
  always_comb begin
    div_slot_t               slot;
    logic signed [ProdW-1:0] pabs;
    logic signed [DiffW-1:0] dv;
    logic signed [DiffW-1:0] dabs;
    logic [1:0]              n;
    n = 2'd0;
    for (int j = 0; j < 2; j++) begin
      sel_next[j]      = '0;
      sel_next[j].dsor = CoordW'(1);
    end
    for (int i = 0; i < NumEdges; i++) begin
      dv   = EdgeHoriz[i] ? s4_aby : s4_abx;
      pabs = s4_dvp[i][ProdW-1] ? -s4_dvp[i] : s4_dvp[i];
      dabs = dv[DiffW-1] ? -dv : dv;
      slot.used  = 1'b1;
      slot.horiz = EdgeHoriz[i];
      slot.neg   = s4_dvp[i][ProdW-1] ^ dv[DiffW-1];
      slot.base  = EdgeHoriz[i] ? s4_ax : s4_ay;
      slot.fixed = EdgeHoriz[i] ? s4_cy[i] : s4_cx[i];
      slot.dsor  = dabs[CoordW-1:0];
      slot.rem   = pabs[MagW-1:CoordW];
      slot.low   = pabs[CoordW-1:0];
      if (s4_hit[i] && n < 2'd2) begin
        sel_next[n[0]] = slot;
        n = n + 2'd1;
      end
    end
    cnt_next = n;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      dsl[0][0] <= sel_next[0];
      dsl[0][1] <= sel_next[1];
      dcnt[0]   <= cnt_next;
    end
  end

  // divider stages: two quotient bits each
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    always_ff @(posedge clk) begin
      div_slot_t d;
      if (adv[5+k]) begin
        for (int j = 0; j < 2; j++) begin
          d = dsl[k][j];
          for (int s = 0; s < DivSteps; s++) begin
            d = div_step(d);
          end
          dsl[k+1][j] <= d;
        end
        dcnt[k+1] <= dcnt[k];
      end
    end
  end

  // final stage: sign the quotient, add the start point, pack
  always_comb begin
    div_slot_t         d;
    logic [CoordW:0]   sq;
    logic [CoordW-1:0] sum;
    logic [CoordW-1:0] px [2];
    logic [CoordW-1:0] py [2];
    for (int j = 0; j < 2; j++) begin
      d   = dsl[DivStages][j];
      sq  = d.neg ? -{1'b0, d.low} : {1'b0, d.low};
      sum = d.base + sq[CoordW-1:0];
      px[j] = '0;
      py[j] = '0;
      if (d.used) begin
        px[j] = d.horiz ? sum : d.fixed;
        py[j] = d.horiz ? d.fixed : sum;
      end
    end
    out_data_next = {6'd0, py[1], px[1], py[0], px[0], dcnt[DivStages]};
  end

  always_ff @(posedge clk) begin
    if (adv[NumStages-1]) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ===== test/tb.sv =====
// Self-checking stream testbench for the segment/rectangle intersection block.
module tb
  import sai_pkg::*;
();

  typedef struct {
    logic [1:0]  hits;
    logic [31:0] fx, fy, sx, sy;
  } isect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ThrW-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  logic [InDataW-1:0] pending_reqs[$];
  isect_t expected_isects[$];
  logic [62:0] threshold;
  int errors = 0;
  int checked = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  bit quiet = 1'b0;
  bit in_taken = 1'b0;
  int stall_cycles = 0;
  int hit_tally[3] = '{0, 0, 0};

  segment_aabb_intersections_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Test one edge; return hit and point.
  function automatic bit edge_test(input longint ax, ay, abx, aby, cx, cy,
                                   input bit horiz, input longint len,
                                   output longint px, py);
    logic signed [127:0] den, snum, tnum, acx, acy;
    logic [127:0] mag;
    longint q;
    acx = cx - ax;
    acy = cy - ay;
    if (horiz) begin
      den = -aby * len;
      snum = -acy * len;
    end else begin
      den = abx * len;
      snum = acx * len;
    end
    mag = den < 0 ? -den : den;
    if (mag == 0 || mag < threshold) return 1'b0;
    tnum = acx * aby - acy * abx;
    if (snum != 0 && ((snum < 0) != (den < 0) || (snum < 0 ? -snum : snum) > mag))
      return 1'b0;
    if (tnum != 0 && ((tnum < 0) != (den < 0) || (tnum < 0 ? -tnum : tnum) > mag))
      return 1'b0;
    // 128-bit signed division truncates toward zero
    if (horiz) begin
      q = (128'sd0 + abx * acy) / aby;
      px = ax + q;
      py = cy;
    end else begin
      q = (128'sd0 + aby * acx) / abx;
      px = cx;
      py = ay + q;
    end
    return 1'b1;
  endfunction

  function automatic isect_t predict_isect(input logic [InDataW-1:0] d);
    longint f[8];
    longint ex[4], ey[4], ln[4], px, py;
    longint hx[2], hy[2];
    isect_t r;
    int n;
    for (int i = 0; i < 8; i++) f[i] = longint'($signed(d[32*i +: 32]));
    ex = '{f[4], f[6], f[6], f[4]};
    ey = '{f[5], f[5], f[7], f[7]};
    ln = '{f[6] - f[4], f[7] - f[5], f[4] - f[6], f[5] - f[7]};
    hx = '{0, 0};
    hy = '{0, 0};
    n = 0;
    for (int i = 0; i < 4 && n < 2; i++) begin
      if (edge_test(f[0], f[1], f[2] - f[0], f[3] - f[1], ex[i], ey[i], EdgeHoriz[i],
                    ln[i], px, py)) begin
        hx[n] = px;
        hy[n] = py;
        n++;
      end
    end
    r.hits = n[1:0];
    r.fx = hx[0][31:0];
    r.fy = hy[0][31:0];
    r.sx = hx[1][31:0];
    r.sy = hy[1][31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  // Mostly segments around the rectangle, some on its edges/corners, some noise.
  function automatic logic [InDataW-1:0] rand_req();
    logic [31:0] v[8];
    int l, t, r, b;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      foreach (v[i]) v[i] = rand_coord();
    end else begin
      l = $signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      t = $signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      r = l + $urandom_range(0, 32'h0040_0000);
      b = t + $urandom_range(0, 32'h0040_0000);
      if ($urandom_range(0, 7) == 0) begin
        int tmp;
        tmp = l; l = r; r = tmp;
      end
      v[4] = l; v[5] = t; v[6] = r; v[7] = b;
      for (int i = 0; i < 4; i++)
        v[i] = $signed($urandom_range(0, 32'h00c0_0000)) - 32'h0060_0000;
      if (kind == 1) begin
        v[0] = l; v[1] = t; v[2] = r; v[3] = b;
      end else if (kind == 2) begin
        v[1] = t;
      end else if (kind == 3) begin
        v[0] = v[2];
      end
    end
    return {v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
  endfunction

  function automatic logic [InDataW-1:0] pack_req(input int v0, v1, v2, v3, v4, v5, v6, v7);
    return {v7, v6, v5, v4, v3, v2, v1, v0};
  endfunction

  task automatic drain_and_idle();
    while (pending_reqs.size() != 0 || expected_isects.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [62:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold = val;
  endtask

  // Record each accepted request and its prediction at the accepting edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_isects.push_back(predict_isect(s_tdata));
      void'(pending_reqs.pop_front());
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Drive requests; bursts of idle between them, never dropping a waiting request.
  always @(negedge clk) begin
    if (!rst) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet && (!s_tvalid || in_taken) && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= pending_reqs.size() != 0;
        if (pending_reqs.size() != 0) s_tdata <= pending_reqs[0];
      end
    end
  end

  // Hold and release the output side.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    isect_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_isects.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = expected_isects.pop_front();
        checked++;
        hit_tally[exp_r.hits]++;
        if (m_tdata[1:0] !== exp_r.hits || m_tdata[33:2] !== exp_r.fx ||
            m_tdata[65:34] !== exp_r.fy || m_tdata[97:66] !== exp_r.sx ||
            m_tdata[129:98] !== exp_r.sy || m_tdata[135:130] !== '0) begin
          $display("%0t: mismatch expected hits=%0d p0=(%h,%h) p1=(%h,%h) actual %h",
                   $time, exp_r.hits, exp_r.fx, exp_r.fy, exp_r.sx, exp_r.sy, m_tdata);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    threshold = 63'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, edges, corners, degenerate shapes, swapped corners.
    pending_reqs.push_back('0);
    pending_reqs.push_back({8{32'h8000_0000}});
    pending_reqs.push_back({8{32'h7fff_ffff}});
    pending_reqs.push_back(pack_req(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_reqs.push_back(pack_req(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                    -100, -100, 100, 100));
    pending_reqs.push_back(pack_req(-200, 0, 200, 0, -100, -100, 100, 100));
    pending_reqs.push_back(pack_req(-200, -100, 200, -100, -100, -100, 100, 100));
    pending_reqs.push_back(pack_req(-200, -200, 200, 200, -100, -100, 100, 100));
    pending_reqs.push_back(pack_req(0, 0, 0, 0, -100, -100, 100, 100));
    pending_reqs.push_back(pack_req(-200, 7, 200, 13, 5, 5, 5, 50));
    pending_reqs.push_back(pack_req(-200, 3, 200, 37, 100, 100, -100, -100));
    pending_reqs.push_back(pack_req(0, 0, 3, 7, -1, -1, 100, 100));
    pending_reqs.push_back(pack_req(-100, 50, 300, -50, -100, -100, 100, 100));
    pending_reqs.push_back(pack_req(1, 1, 300, 1, -100, -100, 100, 100));
    drain_and_idle();

    // Thresholds: zero, large, maximum, and back to one.
    set_threshold('0);
    for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req());
    pending_reqs.push_back(pack_req(-200, 0, 200, 0, -100, -100, 100, 100));
    drain_and_idle();
    set_threshold(63'h0000_0100_0000_0000);
    for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req());
    drain_and_idle();
    set_threshold({63{1'b1}});
    for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req());
    drain_and_idle();
    set_threshold(63'd1);

    // Receiver holds off long while requests keep coming.
    for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
    @(negedge clk);
    hold_off <= 200;
    for (int i = 0; i < 1100; i++) pending_reqs.push_back(rand_req());
    drain_and_idle();
    set_threshold(63'h0000_0000_0001_0000);
    for (int i = 0; i < 200; i++) pending_reqs.push_back(rand_req());
    drain_and_idle();

    // Final stretch at full rate.
    quiet = 1'b1;
    for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
    drain_and_idle();

    $display("Checked %0d results: %0d with no hit, %0d with one, %0d with two,",
             checked, hit_tally[0], hit_tally[1], hit_tally[2]);
    $display("over five threshold settings including zero and the maximum.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sai_pkg.sv
design/segment_aabb_intersections_top.sv
test/tb.sv
